// ===== src/mie_pkg.sv =====
// ----------------------------------------------------------------------------
// mie_pkg
// operation codes, controller states and shared command/status types
// ----------------------------------------------------------------------------
package mie_pkg;

  typedef enum logic [5:0] {
    OP_NOP = 6'd0, OP_MOVN = 6'd1, OP_MOVZ = 6'd2, OP_MFHI = 6'd3, OP_MFLO = 6'd4,
    OP_LB = 6'd5, OP_LH = 6'd6, OP_LW = 6'd7, OP_SB = 6'd8, OP_SH = 6'd9,
    OP_SW = 6'd10, OP_ADD = 6'd11, OP_ADDU = 6'd12, OP_ADDI = 6'd13,
    OP_ADDIU = 6'd14, OP_SUB = 6'd15, OP_SUBU = 6'd16, OP_MUL = 6'd17,
    OP_MULT = 6'd18, OP_MULTU = 6'd19, OP_DIV = 6'd20, OP_DIVU = 6'd21,
    OP_SLT = 6'd22, OP_SLTU = 6'd23, OP_SLTI = 6'd24, OP_SLTIU = 6'd25,
    OP_AND = 6'd26, OP_ANDI = 6'd27, OP_OR = 6'd28, OP_ORI = 6'd29,
    OP_XOR = 6'd30, OP_XORI = 6'd31, OP_NOR = 6'd32, OP_LUI = 6'd33,
    OP_SLL = 6'd34, OP_SLLV = 6'd35, OP_SRA = 6'd36, OP_SRAV = 6'd37,
    OP_SRL = 6'd38, OP_SRLV = 6'd39, OP_J = 6'd40, OP_JAL = 6'd41,
    OP_BLTZ = 6'd42, OP_BLEZ = 6'd43, OP_BGTZ = 6'd44, OP_BGEZ = 6'd45,
    OP_BEQ = 6'd46, OP_BNE = 6'd47
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_DIVZERO  = 2'd2;
  localparam logic [1:0] ST_MISALIGN = 2'd3;

  localparam logic [31:0] REGION_MASK = 32'hf000_0000;
  localparam int unsigned DIV_STEPS = 32;

  typedef enum logic [2:0] {
    S_IDLE,    // waiting for a request
    S_READ,    // operands registered, word quotient computed
    S_ADDR,    // word slot settles, memory read
    S_MUL,     // product register settles
    S_DIV,     // one quotient bit a cycle
    S_FINISH,  // state update, result loaded
    S_HOLD     // result waiting for the receiver
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch request fields
    logic mul_start;  // register operands into the multiplier
    logic div_start;  // load the divider
    logic div_step;   // one divider iteration
    logic finish;     // commit state and load the result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_mul;     // MULT or MULTU
    logic is_div;     // DIV or DIVU with a nonzero divisor
    logic div_last;   // final divider iteration this cycle
  } stat_t;

endpackage

// ===== src/mie_ctrl.sv =====
// ----------------------------------------------------------------------------
// mie_ctrl
// sequencer for one instruction: read, optional multiply/divide, commit, hold
// ----------------------------------------------------------------------------
module mie_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  mie_pkg::stat_t  stat,
  output mie_pkg::cmd_t   cmd
);

  mie_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mie_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      mie_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = mie_pkg::S_READ;
        end
      end
      mie_pkg::S_READ: state_next = mie_pkg::S_ADDR;
      mie_pkg::S_ADDR: begin
        if (stat.is_mul) begin
          cmd.mul_start = 1'b1;
          state_next = mie_pkg::S_MUL;
        end else if (stat.is_div) begin
          cmd.div_start = 1'b1;
          state_next = mie_pkg::S_DIV;
        end else begin
          state_next = mie_pkg::S_FINISH;
        end
      end
      mie_pkg::S_MUL: state_next = mie_pkg::S_FINISH;
      mie_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = mie_pkg::S_FINISH;
      end
      mie_pkg::S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = mie_pkg::S_HOLD;
      end
      mie_pkg::S_HOLD: begin
        out_valid = 1'b1;
        in_stall = out_stall;
        if (!out_stall) begin
          if (in_valid) begin
            cmd.capture = 1'b1;
            state_next = mie_pkg::S_READ;
          end else begin
            state_next = mie_pkg::S_IDLE;
          end
        end
      end
      default: state_next = mie_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== src/mie_dp.sv =====
// ----------------------------------------------------------------------------
// mie_dp
// register file, hi/lo, program counter, data memory, alu, multiplier, divider
// ----------------------------------------------------------------------------
module mie_dp #(
  parameter int unsigned MEM_WORDS = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  reset_pc_we,
  input  logic [31:0]           reset_pc_data,
  input  logic [5:0]            operation,
  input  logic [4:0]            dest_index,
  input  logic [4:0]            src_a_index,
  input  logic [4:0]            src_b_index,
  input  logic [15:0]           immediate,
  input  logic [4:0]            shift_amount,
  input  logic [25:0]           jump_target,
  input  mie_pkg::cmd_t         cmd,
  output mie_pkg::stat_t        stat,
  output logic [31:0]           next_pc,
  output logic [1:0]            status,
  output logic                  reg_written,
  output logic [4:0]            written_index,
  output logic [31:0]           written_value
);

  localparam int unsigned AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int unsigned CW = $clog2(mie_pkg::DIV_STEPS);

  // captured request
  mie_pkg::op_t op;
  logic [4:0]  rd, rs, rt, sa;
  logic [15:0] imm;
  logic [25:0] tgt;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op  <= mie_pkg::op_t'(operation);
      rd  <= dest_index;
      rs  <= src_a_index;
      rt  <= src_b_index;
      imm <= immediate;
      sa  <= shift_amount;
      tgt <= jump_target;
    end
  end

  // architectural state
  logic [31:0] gpr [32];
  logic [31:0] hi, lo, pc;
  logic [31:0] mem [MEM_WORDS];

  // operand read, registered
  logic [31:0] a, b, mem_word;
  logic [31:0] simm, addr;
  logic [AW-1:0] slot;

  assign simm = {{16{imm[15]}}, imm};
  assign addr = a + simm;

  // word number wraps modulo MEM_WORDS
  generate
    if ((MEM_WORDS & (MEM_WORDS - 1)) == 0) begin : g_slot_pow2
      assign slot = addr[AW+1:2];
    end else begin : g_slot_recip
      // quotient by reciprocal multiply, registered; remainder in the next cycle
      localparam int unsigned SH = 30 + AW;
      localparam logic [63:0] RECIP =
        ((64'd1 << SH) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS);
      logic [63:0] wprod;
      logic [29:0] wq, wrem;
      assign wprod = {34'd0, addr[31:2]} * RECIP;
      always_ff @(posedge clk) begin
        wq <= 30'(wprod >> SH);
      end
      assign wrem = addr[31:2] - wq * 30'(MEM_WORDS);
      assign slot = wrem[AW-1:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      a <= (src_a_index == 5'd0) ? 32'd0 : gpr[src_a_index];
      b <= (src_b_index == 5'd0) ? 32'd0 : gpr[src_b_index];
    end
  end

  // memory read port, valid by the finish cycle
  always_ff @(posedge clk) begin
    mem_word <= mem[slot];
  end

  // multiplier: operands registered, product registered
  logic [63:0] prod;
  logic        m_signed;
  assign m_signed = (op == mie_pkg::OP_MULT);
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      prod <= 64'($signed(m_signed ? {a[31], a} : {1'b0, a})
                 * $signed(m_signed ? {b[31], b} : {1'b0, b}));
    end
  end

  // restoring divider on magnitudes, one bit a cycle
  logic [31:0] dq, dd, dr;
  logic [CW-1:0] dcnt;
  logic        dneg_q, dneg_r;
  logic [32:0] dtrial;
  logic [31:0] rem_sh;
  logic        d_signed;
  assign d_signed = (op == mie_pkg::OP_DIV);
  assign rem_sh = {dr[30:0], dq[31]};
  assign dtrial = {dr[31], rem_sh} - {1'b0, dd};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq <= (d_signed && a[31]) ? -a : a;
      dd <= (d_signed && b[31]) ? -b : b;
      dr <= '0;
      dcnt <= '0;
      dneg_q <= d_signed && (a[31] ^ b[31]);
      dneg_r <= d_signed && a[31];
    end else if (cmd.div_step) begin
      if (!dtrial[32]) begin
        dr <= dtrial[31:0];
        dq <= {dq[30:0], 1'b1};
      end else begin
        dr <= rem_sh;
        dq <= {dq[30:0], 1'b0};
      end
      dcnt <= dcnt + 1'b1;
    end
  end

  assign stat.is_mul = (op == mie_pkg::OP_MULT) || (op == mie_pkg::OP_MULTU);
  assign stat.is_div = ((op == mie_pkg::OP_DIV) || (op == mie_pkg::OP_DIVU)) && (b != 0);
  assign stat.div_last = (dcnt == CW'(mie_pkg::DIV_STEPS - 1));

  // execute
  logic [31:0] pc4, npc, wval, r, lane_w, st_word;
  logic [4:0]  widx, lane;
  logic        wr, take, mem_we, hilo_we;
  logic [1:0]  st;
  logic [31:0] hi_new, lo_new;

  always_comb begin
    pc4 = pc + 32'd4;
    npc = pc4;
    st = mie_pkg::ST_OK;
    wr = 1'b0;
    widx = rd;
    wval = '0;
    take = 1'b0;
    mem_we = 1'b0;
    st_word = mem_word;
    hilo_we = 1'b0;
    hi_new = hi;
    lo_new = lo;
    lane = {addr[1:0], 3'b000};
    lane_w = mem_word >> lane;
    r = '0;
    case (op)
      mie_pkg::OP_MOVN: begin wr = (b != 0); wval = a; end
      mie_pkg::OP_MOVZ: begin wr = (b == 0); wval = a; end
      mie_pkg::OP_MFHI: begin wr = 1'b1; wval = hi; end
      mie_pkg::OP_MFLO: begin wr = 1'b1; wval = lo; end
      mie_pkg::OP_LB: begin
        wr = 1'b1; widx = rt; wval = {{24{lane_w[7]}}, lane_w[7:0]};
      end
      mie_pkg::OP_LH: begin
        if (addr[0]) st = mie_pkg::ST_MISALIGN;
        else begin wr = 1'b1; widx = rt; wval = {{16{lane_w[15]}}, lane_w[15:0]}; end
      end
      mie_pkg::OP_LW: begin
        if (addr[1:0] != 2'b00) st = mie_pkg::ST_MISALIGN;
        else begin wr = 1'b1; widx = rt; wval = mem_word; end
      end
      mie_pkg::OP_SB: begin
        mem_we = 1'b1;
        st_word = (mem_word & ~(32'hff << lane)) | ({24'd0, b[7:0]} << lane);
      end
      mie_pkg::OP_SH: begin
        if (addr[0]) st = mie_pkg::ST_MISALIGN;
        else begin
          mem_we = 1'b1;
          st_word = (mem_word & ~(32'hffff << lane)) | ({16'd0, b[15:0]} << lane);
        end
      end
      mie_pkg::OP_SW: begin
        if (addr[1:0] != 2'b00) st = mie_pkg::ST_MISALIGN;
        else begin mem_we = 1'b1; st_word = b; end
      end
      mie_pkg::OP_ADD: begin
        r = a + b;
        if (((a ^ r) & (b ^ r)) >> 31 != 0) st = mie_pkg::ST_OVERFLOW;
        else begin wr = 1'b1; wval = r; end
      end
      mie_pkg::OP_ADDU: begin wr = 1'b1; wval = a + b; end
      mie_pkg::OP_ADDI: begin
        r = addr;
        widx = rt;
        if (((a ^ r) & (simm ^ r)) >> 31 != 0) st = mie_pkg::ST_OVERFLOW;
        else begin wr = 1'b1; wval = r; end
      end
      mie_pkg::OP_ADDIU: begin wr = 1'b1; widx = rt; wval = addr; end
      mie_pkg::OP_SUB: begin
        r = a - b;
        if (((a ^ b) & (a ^ r)) >> 31 != 0) st = mie_pkg::ST_OVERFLOW;
        else begin wr = 1'b1; wval = r; end
      end
      mie_pkg::OP_SUBU: begin wr = 1'b1; wval = a - b; end
      mie_pkg::OP_MUL: begin wr = 1'b1; wval = a * b; end
      mie_pkg::OP_MULT, mie_pkg::OP_MULTU: begin
        hilo_we = 1'b1; hi_new = prod[63:32]; lo_new = prod[31:0];
      end
      mie_pkg::OP_DIV, mie_pkg::OP_DIVU: begin
        if (b == 0) st = mie_pkg::ST_DIVZERO;
        else begin
          hilo_we = 1'b1;
          lo_new = dneg_q ? -dq : dq;
          hi_new = dneg_r ? -dr : dr;
        end
      end
      mie_pkg::OP_SLT: begin wr = 1'b1; wval = {31'd0, $signed(a) < $signed(b)}; end
      mie_pkg::OP_SLTU: begin wr = 1'b1; wval = {31'd0, a < b}; end
      mie_pkg::OP_SLTI: begin
        wr = 1'b1; widx = rt; wval = {31'd0, $signed(a) < $signed(simm)};
      end
      mie_pkg::OP_SLTIU: begin wr = 1'b1; widx = rt; wval = {31'd0, a < simm}; end
      mie_pkg::OP_AND: begin wr = 1'b1; wval = a & b; end
      mie_pkg::OP_ANDI: begin wr = 1'b1; widx = rt; wval = a & {16'd0, imm}; end
      mie_pkg::OP_OR: begin wr = 1'b1; wval = a | b; end
      mie_pkg::OP_ORI: begin wr = 1'b1; widx = rt; wval = a | {16'd0, imm}; end
      mie_pkg::OP_XOR: begin wr = 1'b1; wval = a ^ b; end
      mie_pkg::OP_XORI: begin wr = 1'b1; widx = rt; wval = a ^ {16'd0, imm}; end
      mie_pkg::OP_NOR: begin wr = 1'b1; wval = ~(a | b); end
      mie_pkg::OP_LUI: begin wr = 1'b1; widx = rt; wval = {imm, 16'd0}; end
      mie_pkg::OP_SLL: begin wr = 1'b1; wval = b << sa; end
      mie_pkg::OP_SLLV: begin wr = 1'b1; wval = b << a[4:0]; end
      mie_pkg::OP_SRA: begin wr = 1'b1; wval = 32'($signed(b) >>> sa); end
      mie_pkg::OP_SRAV: begin wr = 1'b1; wval = 32'($signed(b) >>> a[4:0]); end
      mie_pkg::OP_SRL: begin wr = 1'b1; wval = b >> sa; end
      mie_pkg::OP_SRLV: begin wr = 1'b1; wval = b >> a[4:0]; end
      mie_pkg::OP_J: npc = (pc4 & mie_pkg::REGION_MASK) | {4'd0, tgt, 2'b00};
      mie_pkg::OP_JAL: begin
        wr = 1'b1; widx = 5'd31; wval = pc + 32'd8;
        npc = (pc4 & mie_pkg::REGION_MASK) | {4'd0, tgt, 2'b00};
      end
      mie_pkg::OP_BLTZ: take = a[31];
      mie_pkg::OP_BLEZ: take = a[31] || (a == 0);
      mie_pkg::OP_BGTZ: take = !a[31] && (a != 0);
      mie_pkg::OP_BGEZ: take = !a[31];
      mie_pkg::OP_BEQ: take = (a == b);
      mie_pkg::OP_BNE: take = (a != b);
      default: ;
    endcase
    if (take) npc = pc4 + {simm[29:0], 2'b00};
    if (!wr || widx == 5'd0) begin
      wr = 1'b0; widx = '0; wval = '0;
    end
  end

  // state commit
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
      hi <= '0;
      lo <= '0;
      for (int i = 0; i < 32; i++) gpr[i] <= '0;
    end else if (reset_pc_we) begin
      pc <= reset_pc_data;
    end else if (cmd.finish) begin
      pc <= npc;
      if (hilo_we) begin hi <= hi_new; lo <= lo_new; end
      if (wr) gpr[widx] <= wval;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && mem_we) mem[slot] <= st_word;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      next_pc <= npc;
      status <= st;
      reg_written <= wr;
      written_index <= widx;
      written_value <= wval;
    end
  end

endmodule

// ===== src/mips32_integer_execute.sv =====
// ----------------------------------------------------------------------------
// mips32_integer_execute
// executes one decoded MIPS32 integer instruction per request
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with the decoded instruction fields.
// Output channel: out_valid/out_stall with next_pc, status and the register
// write. One request is worked at a time; the result sits in an output
// register, and the next request is taken in the same cycle as it leaves.
// Each request steps through operand read, word slot and memory read, and
// commit; MULT/MULTU add one registered multiplier stage, and DIV/DIVU with a
// nonzero divisor run through the restoring divider, one quotient bit a cycle.
// Reset clears all general registers, HI, LO and the program counter;
// writing reset_pc (reset_pc_we) loads it into the program counter too.
// The data memory has no reset; a word must be stored before it is loaded.
// While the receiver stalls, the result holds and no request is taken.
module mips32_integer_execute #(
  parameter int unsigned MEM_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        reset_pc_we,
  input  logic [31:0] reset_pc,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  operation,
  input  logic [4:0]  dest_index,
  input  logic [4:0]  src_a_index,
  input  logic [4:0]  src_b_index,
  input  logic [15:0] immediate,
  input  logic [4:0]  shift_amount,
  input  logic [25:0] jump_target,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] next_pc,
  output logic [1:0]  status,
  output logic        reg_written,
  output logic [4:0]  written_index,
  output logic [31:0] written_value
);

  mie_pkg::cmd_t  cmd;
  mie_pkg::stat_t stat;

  // sequencer
  mie_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
  );

  // datapath
  mie_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
    .clk(clk), .rst(rst), .reset_pc_we(reset_pc_we), .reset_pc_data(reset_pc),
    .operation(operation), .dest_index(dest_index), .src_a_index(src_a_index),
    .src_b_index(src_b_index), .immediate(immediate), .shift_amount(shift_amount),
    .jump_target(jump_target), .cmd(cmd), .stat(stat), .next_pc(next_pc),
    .status(status), .reg_written(reg_written), .written_index(written_index),
    .written_value(written_value)
  );

endmodule

// ===== src/mie_checker.sv =====
// ----------------------------------------------------------------------------
// mie_checker
// port-level checks on the execute block
// ----------------------------------------------------------------------------
module mie_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic        reg_written,
  input logic [4:0]  written_index,
  input logic [31:0] written_value,
  input logic [31:0] next_pc
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(next_pc) && $stable(written_value))
    else $error("result changed under stall");

  // register zero is never reported written
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && reg_written |-> written_index != 5'd0)
    else $error("write to register zero reported");

  // no write reported with a nonzero status
  a_trap: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != 2'd0 |-> !reg_written)
    else $error("write reported with trap status");

  // an accepted request is not followed by a result in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid)
    else $error("result too early");

endmodule

bind mips32_integer_execute mie_checker u_mie_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .status(status),
  .reg_written(reg_written), .written_index(written_index),
  .written_value(written_value), .next_pc(next_pc)
);

// ===== tb/sv/mips32_integer_execute_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mips32_integer_execute_tb
// self-checking bench for the integer execute block
// ----------------------------------------------------------------------------
// Every request is run through an in-bench copy of the instruction set
// (registers, HI/LO, program counter, byte-lane data memory) when it is
// queued. The expected result travels with the request and moves to the
// result queue when the block accepts it. Both channels idle at random, the
// receiver holds off once for a long stretch and the sender drains once.
// The run steps through several reset_pc settings, extremes included.
// ----------------------------------------------------------------------------
module mips32_integer_execute_tb;

  localparam int MEM_WORDS   = 1024;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [5:0]  op;
    logic [4:0]  rd, rs, rt, sa;
    logic [15:0] imm;
    logic [25:0] tgt;
    logic [31:0] npc;
    logic [1:0]  st;
    logic        wr;
    logic [4:0]  widx;
    logic [31:0] wval;
  } request_t;

  logic        clk = 0, rst = 1;
  logic        reset_pc_we = 0;
  logic [31:0] reset_pc = 0;
  logic        in_valid = 0, out_stall = 0;
  logic [5:0]  operation = 0;
  logic [4:0]  dest_index = 0, src_a_index = 0, src_b_index = 0, shift_amount = 0;
  logic [15:0] immediate = 0;
  logic [25:0] jump_target = 0;
  logic        in_stall, out_valid, reg_written;
  logic [31:0] next_pc, written_value;
  logic [1:0]  status;
  logic [4:0]  written_index;

  mips32_integer_execute #(.MEM_WORDS(MEM_WORDS)) dut (
    .clk(clk), .rst(rst), .reset_pc_we(reset_pc_we), .reset_pc(reset_pc),
    .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
    .dest_index(dest_index), .src_a_index(src_a_index), .src_b_index(src_b_index),
    .immediate(immediate), .shift_amount(shift_amount), .jump_target(jump_target),
    .out_valid(out_valid), .out_stall(out_stall), .next_pc(next_pc), .status(status),
    .reg_written(reg_written), .written_index(written_index),
    .written_value(written_value)
  );

  always #5 clk = ~clk;

  // architectural state mirrored in the bench
  logic [31:0] gpr [32];
  logic [31:0] hi_q, lo_q, pc_q;
  logic [31:0] mem_q [MEM_WORDS];
  logic [3:0]  lane_ok [MEM_WORDS];

  request_t pending_requests[$];
  request_t expected_results[$];
  request_t cur;
  int errors = 0, sent_count = 0, result_count = 0, trap_count = 0, cycles = 0;

  function automatic logic [31:0] sext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] reg_read(logic [4:0] i);
    return (i == 0) ? 32'd0 : gpr[i];
  endfunction

  // true when a load would touch bytes never stored
  function automatic bit load_unsafe(logic [5:0] op, logic [4:0] rs, logic [15:0] imm);
    logic [31:0] addr;
    int slot;
    logic [3:0] need;
    addr = reg_read(rs) + sext16(imm);
    slot = (addr >> 2) % MEM_WORDS;
    case (op)
      mie_pkg::OP_LB: need = 4'b0001 << addr[1:0];
      mie_pkg::OP_LH: need = addr[0] ? 4'b0000 : (4'b0011 << addr[1:0]);
      mie_pkg::OP_LW: need = (addr[1:0] != 0) ? 4'b0000 : 4'b1111;
      default: need = 4'b0000;
    endcase
    return (need & ~lane_ok[slot]) != 0;
  endfunction

  // executes one instruction against the mirrored state
  function automatic void execute_instr(ref request_t r);
    logic [31:0] a, b, simm, pc4, addr, res;
    logic [63:0] prod;
    longint sq, sr;
    int slot, lane;
    bit take;
    a = reg_read(r.rs);
    b = reg_read(r.rt);
    simm = sext16(r.imm);
    pc4 = pc_q + 32'd4;
    addr = a + simm;
    slot = (addr >> 2) % MEM_WORDS;
    lane = addr[1:0] * 8;
    take = 0;
    r.npc = pc4; r.st = mie_pkg::ST_OK; r.wr = 0; r.widx = 0; r.wval = 0;
    case (r.op)
      mie_pkg::OP_MOVN: if (b != 0) begin r.wr = 1; r.widx = r.rd; r.wval = a; end
      mie_pkg::OP_MOVZ: if (b == 0) begin r.wr = 1; r.widx = r.rd; r.wval = a; end
      mie_pkg::OP_MFHI: begin r.wr = 1; r.widx = r.rd; r.wval = hi_q; end
      mie_pkg::OP_MFLO: begin r.wr = 1; r.widx = r.rd; r.wval = lo_q; end
      mie_pkg::OP_LB: begin
        res = (mem_q[slot] >> lane) & 32'hff;
        r.wr = 1; r.widx = r.rt; r.wval = {{24{res[7]}}, res[7:0]};
      end
      mie_pkg::OP_LH: if (addr[0]) r.st = mie_pkg::ST_MISALIGN;
        else begin
          res = mem_q[slot] >> lane;
          r.wr = 1; r.widx = r.rt; r.wval = sext16(res[15:0]);
        end
      mie_pkg::OP_LW: if (addr[1:0] != 0) r.st = mie_pkg::ST_MISALIGN;
        else begin r.wr = 1; r.widx = r.rt; r.wval = mem_q[slot]; end
      mie_pkg::OP_SB: begin
        mem_q[slot] = (mem_q[slot] & ~(32'hff << lane)) | ((b & 32'hff) << lane);
        lane_ok[slot] |= 4'b0001 << addr[1:0];
      end
      mie_pkg::OP_SH: if (addr[0]) r.st = mie_pkg::ST_MISALIGN;
        else begin
          mem_q[slot] = (mem_q[slot] & ~(32'hffff << lane)) | ((b & 32'hffff) << lane);
          lane_ok[slot] |= 4'b0011 << addr[1:0];
        end
      mie_pkg::OP_SW: if (addr[1:0] != 0) r.st = mie_pkg::ST_MISALIGN;
        else begin mem_q[slot] = b; lane_ok[slot] = 4'b1111; end
      mie_pkg::OP_ADD: begin
        res = a + b;
        if (((a ^ res) & (b ^ res)) >> 31) r.st = mie_pkg::ST_OVERFLOW;
        else begin r.wr = 1; r.widx = r.rd; r.wval = res; end
      end
      mie_pkg::OP_ADDU: begin r.wr = 1; r.widx = r.rd; r.wval = a + b; end
      mie_pkg::OP_ADDI: begin
        res = a + simm;
        if (((a ^ res) & (simm ^ res)) >> 31) r.st = mie_pkg::ST_OVERFLOW;
        else begin r.wr = 1; r.widx = r.rt; r.wval = res; end
      end
      mie_pkg::OP_ADDIU: begin r.wr = 1; r.widx = r.rt; r.wval = a + simm; end
      mie_pkg::OP_SUB: begin
        res = a - b;
        if (((a ^ b) & (a ^ res)) >> 31) r.st = mie_pkg::ST_OVERFLOW;
        else begin r.wr = 1; r.widx = r.rd; r.wval = res; end
      end
      mie_pkg::OP_SUBU: begin r.wr = 1; r.widx = r.rd; r.wval = a - b; end
      mie_pkg::OP_MUL: begin r.wr = 1; r.widx = r.rd; r.wval = a * b; end
      mie_pkg::OP_MULT: begin
        prod = longint'($signed(a)) * longint'($signed(b));
        lo_q = prod[31:0]; hi_q = prod[63:32];
      end
      mie_pkg::OP_MULTU: begin
        prod = {32'd0, a} * {32'd0, b};
        lo_q = prod[31:0]; hi_q = prod[63:32];
      end
      mie_pkg::OP_DIV: if (b == 0) r.st = mie_pkg::ST_DIVZERO;
        else begin
          sq = longint'($signed(a)) / longint'($signed(b));
          sr = longint'($signed(a)) % longint'($signed(b));
          lo_q = sq[31:0]; hi_q = sr[31:0];
        end
      mie_pkg::OP_DIVU: if (b == 0) r.st = mie_pkg::ST_DIVZERO;
        else begin lo_q = a / b; hi_q = a % b; end
      mie_pkg::OP_SLT: begin
        r.wr = 1; r.widx = r.rd; r.wval = {31'd0, $signed(a) < $signed(b)};
      end
      mie_pkg::OP_SLTU: begin r.wr = 1; r.widx = r.rd; r.wval = {31'd0, a < b}; end
      mie_pkg::OP_SLTI: begin
        r.wr = 1; r.widx = r.rt; r.wval = {31'd0, $signed(a) < $signed(simm)};
      end
      mie_pkg::OP_SLTIU: begin r.wr = 1; r.widx = r.rt; r.wval = {31'd0, a < simm}; end
      mie_pkg::OP_AND:   begin r.wr = 1; r.widx = r.rd; r.wval = a & b; end
      mie_pkg::OP_ANDI:  begin r.wr = 1; r.widx = r.rt; r.wval = a & {16'd0, r.imm}; end
      mie_pkg::OP_OR:    begin r.wr = 1; r.widx = r.rd; r.wval = a | b; end
      mie_pkg::OP_ORI:   begin r.wr = 1; r.widx = r.rt; r.wval = a | {16'd0, r.imm}; end
      mie_pkg::OP_XOR:   begin r.wr = 1; r.widx = r.rd; r.wval = a ^ b; end
      mie_pkg::OP_XORI:  begin r.wr = 1; r.widx = r.rt; r.wval = a ^ {16'd0, r.imm}; end
      mie_pkg::OP_NOR:   begin r.wr = 1; r.widx = r.rd; r.wval = ~(a | b); end
      mie_pkg::OP_LUI:   begin r.wr = 1; r.widx = r.rt; r.wval = {r.imm, 16'd0}; end
      mie_pkg::OP_SLL:   begin r.wr = 1; r.widx = r.rd; r.wval = b << r.sa; end
      mie_pkg::OP_SLLV:  begin r.wr = 1; r.widx = r.rd; r.wval = b << a[4:0]; end
      mie_pkg::OP_SRA:   begin r.wr = 1; r.widx = r.rd; r.wval = $signed(b) >>> r.sa; end
      mie_pkg::OP_SRAV:  begin r.wr = 1; r.widx = r.rd; r.wval = $signed(b) >>> a[4:0]; end
      mie_pkg::OP_SRL:   begin r.wr = 1; r.widx = r.rd; r.wval = b >> r.sa; end
      mie_pkg::OP_SRLV:  begin r.wr = 1; r.widx = r.rd; r.wval = b >> a[4:0]; end
      mie_pkg::OP_J: r.npc = (pc4 & mie_pkg::REGION_MASK) | {4'd0, r.tgt, 2'd0};
      mie_pkg::OP_JAL: begin
        r.wr = 1; r.widx = 5'd31; r.wval = pc_q + 32'd8;
        r.npc = (pc4 & mie_pkg::REGION_MASK) | {4'd0, r.tgt, 2'd0};
      end
      mie_pkg::OP_BLTZ: take = a[31];
      mie_pkg::OP_BLEZ: take = a[31] || a == 0;
      mie_pkg::OP_BGTZ: take = !a[31] && a != 0;
      mie_pkg::OP_BGEZ: take = !a[31];
      mie_pkg::OP_BEQ:  take = (a == b);
      mie_pkg::OP_BNE:  take = (a != b);
      default: ;
    endcase
    if (take) r.npc = pc4 + (simm << 2);
    if (r.wr && r.widx != 0) gpr[r.widx] = r.wval;
    else begin r.wr = 0; r.widx = 0; r.wval = 0; end
    pc_q = r.npc;
  endfunction

  // queue one request with its predicted result
  task automatic queue_instr(logic [5:0] op, logic [4:0] rd, logic [4:0] rs, logic [4:0] rt,
                             logic [15:0] imm, logic [4:0] sa, logic [25:0] tgt);
    request_t r;
    if (load_unsafe(op, rs, imm)) op = mie_pkg::OP_SB;
    r.op = op; r.rd = rd; r.rs = rs; r.rt = rt; r.imm = imm; r.sa = sa; r.tgt = tgt;
    execute_instr(r);
    if (r.st != mie_pkg::ST_OK) trap_count++;
    pending_requests.push_back(r);
  endtask

  task automatic random_instr();
    logic [5:0] op;
    logic [4:0] rs;
    int pick;
    pick = $urandom_range(99);
    rs = 5'($urandom);
    if (pick < 30) begin
      // memory traffic near address zero so loads find stored data
      case ($urandom_range(5))
        0: op = mie_pkg::OP_LB; 1: op = mie_pkg::OP_LH; 2: op = mie_pkg::OP_LW;
        3: op = mie_pkg::OP_SB; 4: op = mie_pkg::OP_SH; default: op = mie_pkg::OP_SW;
      endcase
      if ($urandom_range(3) != 0) rs = 0;
      queue_instr(op, 5'($urandom), rs, 5'($urandom),
                  $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(63)),
                  5'($urandom), 26'($urandom));
    end else if (pick < 40) begin
      // load wide constants to get signed and unsigned extremes
      queue_instr($urandom_range(1) ? mie_pkg::OP_LUI : mie_pkg::OP_ORI, 5'($urandom),
                  5'($urandom), 5'($urandom), 16'($urandom), 5'($urandom), 26'($urandom));
    end else begin
      queue_instr(6'($urandom_range(63)), 5'($urandom), rs, 5'($urandom), 16'($urandom),
                  5'($urandom), 26'($urandom));
    end
  endtask

  task automatic directed_instrs();
    queue_instr(mie_pkg::OP_LUI,   0, 0, 1, 16'h8000, 0, 0);   // r1 = most negative
    queue_instr(mie_pkg::OP_ADDIU, 0, 0, 2, 16'hffff, 0, 0);   // r2 = -1
    queue_instr(mie_pkg::OP_LUI,   0, 0, 3, 16'h7fff, 0, 0);
    queue_instr(mie_pkg::OP_ORI,   0, 3, 3, 16'hffff, 0, 0);   // r3 = most positive
    queue_instr(mie_pkg::OP_ADD,   4, 3, 3, 0, 0, 0);          // overflow trap
    queue_instr(mie_pkg::OP_SUB,   4, 1, 3, 0, 0, 0);          // overflow trap
    queue_instr(mie_pkg::OP_ADDI,  0, 3, 4, 16'h0001, 0, 0);   // overflow trap
    queue_instr(mie_pkg::OP_DIV,   0, 1, 2, 0, 0, 0);          // most negative by -1
    queue_instr(mie_pkg::OP_MFHI,  5, 0, 0, 0, 0, 0);
    queue_instr(mie_pkg::OP_MFLO,  6, 0, 0, 0, 0, 0);
    queue_instr(mie_pkg::OP_DIVU,  0, 3, 0, 0, 0, 0);          // divide by zero
    queue_instr(mie_pkg::OP_MULTU, 0, 2, 2, 0, 0, 0);
    queue_instr(mie_pkg::OP_MFHI,  7, 0, 0, 0, 0, 0);
    queue_instr(mie_pkg::OP_MULT,  0, 1, 2, 0, 0, 0);
    queue_instr(mie_pkg::OP_MFLO,  8, 0, 0, 0, 0, 0);
    queue_instr(mie_pkg::OP_SW,    0, 0, 2, 16'h0000, 0, 0);
    queue_instr(mie_pkg::OP_LB,    0, 0, 9, 16'h0003, 0, 0);
    queue_instr(mie_pkg::OP_LH,    0, 0, 10, 16'h0001, 0, 0);  // misaligned half
    queue_instr(mie_pkg::OP_LW,    0, 0, 11, 16'h0002, 0, 0);  // misaligned word
    queue_instr(mie_pkg::OP_SLTU,  12, 1, 3, 0, 0, 0);
    queue_instr(mie_pkg::OP_SLTIU, 0, 3, 13, 16'h8000, 0, 0);
    queue_instr(mie_pkg::OP_ADDU,  0, 2, 2, 0, 31, 0);         // write to register zero
    queue_instr(mie_pkg::OP_SRA,   14, 0, 1, 0, 31, 0);
    queue_instr(mie_pkg::OP_JAL,   0, 0, 0, 0, 0, 26'h3ffffff);
    queue_instr(mie_pkg::OP_BEQ,   0, 0, 0, 16'h8000, 0, 0);   // taken, most negative offset
  endtask

  function automatic bit sender_idle();
    return (cycles < 3000 || cycles > 8000) && $urandom_range(99) < 25;
  endfunction

  // request driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(cur);
        sent_count <= sent_count + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() > 0 && !sender_idle() &&
            !(sent_count == 900 && expected_results.size() > 0)) begin
          cur = pending_requests.pop_front();
          operation <= cur.op; dest_index <= cur.rd; src_a_index <= cur.rs;
          src_b_index <= cur.rt; immediate <= cur.imm; shift_amount <= cur.sa;
          jump_target <= cur.tgt;
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : monitor
    request_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: next_pc %h", next_pc);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (next_pc !== e.npc) begin
            $error("next_pc expected %h actual %h", e.npc, next_pc); errors++;
          end
          if (status !== e.st) begin
            $error("status expected %0d actual %0d", e.st, status); errors++;
          end
          if (reg_written !== e.wr) begin
            $error("reg_written expected %0d actual %0d", e.wr, reg_written); errors++;
          end
          if (written_index !== e.widx) begin
            $error("written_index expected %0d actual %0d", e.widx, written_index); errors++;
          end
          if (written_value !== e.wval) begin
            $error("written_value expected %h actual %h", e.wval, written_value); errors++;
          end
        end
        result_count++;
      end
    end
  end

  // receiver stall, with one long hold-off
  int hold_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (cycles == 5000) hold_left = 400;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1;
      end else begin
        out_stall <= (cycles < 4000 || cycles > 9000) && $urandom_range(99) < 25;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reset_pc(logic [31:0] v);
    @(posedge clk);
    reset_pc_we <= 1;
    reset_pc <= v;
    pc_q = v;
    @(posedge clk);
    reset_pc_we <= 0;
  endtask

  task automatic wait_drained();
    while (pending_requests.size() > 0 || expected_results.size() > 0 || in_valid)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  logic [31:0] pc_settings [4];
  initial begin
    for (int i = 0; i < 32; i++) gpr[i] = 0;
    hi_q = 0; lo_q = 0; pc_q = 0;
    for (int i = 0; i < MEM_WORDS; i++) begin mem_q[i] = 0; lane_ok[i] = 0; end
    pc_settings[0] = 32'h0000_0000;
    pc_settings[1] = 32'hffff_fff8;
    pc_settings[2] = $urandom & 32'hffff_fffc;
    pc_settings[3] = 32'hbfc0_0000;
    repeat (7) @(posedge clk);
    rst <= 0;
    for (int p = 0; p < 4; p++) begin
      write_reset_pc(pc_settings[p]);
      if (p == 0) directed_instrs();
      for (int i = 0; i < 370; i++) random_instr();
      wait_drained();
    end
    $display("executed %0d instructions over 4 reset_pc settings, %0d results, %0d traps",
             sent_count, result_count, trap_count);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
